// ===== design/lpht_pkg.sv =====
// Shared types and codes for the linear-probe hash table.
package lpht_pkg;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int SSTATE_W = 2;
    localparam int MID_W    = 8;
    localparam int SQ_W     = 32;
    localparam int MID_LSB  = 12;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [SSTATE_W-1:0] SS_EMPTY = 2'd0;
    localparam logic [SSTATE_W-1:0] SS_USED  = 2'd1;
    localparam logic [SSTATE_W-1:0] SS_GONE  = 2'd2;

    localparam logic [STATUS_W-1:0] RES_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] RES_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] RES_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] RES_DELETED  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE
    } fsm_t;

endpackage

// ===== design/linear_probe_hash_table_unit.sv =====
// Hash table top level: mid-square hash, reciprocal reduction, one-slot-per-cycle probing.
// Sequence: start accepted -> squarer (ST_HASH) -> reciprocal-multiply reduction in ST_MOD
//   (quotient, then remainder) -> one probe per slot, p = slots probed (1..TABLE_SIZE);
//   the done strobe is registered.
// A new start is taken only while busy is low; busy stays high from the squarer through the
//   last probe. done is high for a single cycle; status and slot hold until the next result.
// Reset (rst_n low, async): sequencer idle, all slot valid bits cleared (every slot never used).
module linear_probe_hash_table_unit #(
    parameter int TABLE_SIZE = 11,
    parameter int KEY_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lpht_pkg::REQ_W-1:0]     req_type,
    input  logic [lpht_pkg::KEY_W-1:0]     key,
    output logic                           busy,
    output logic                           done,
    output logic [lpht_pkg::STATUS_W-1:0]  status,
    output logic [lpht_pkg::SLOT_W-1:0]    slot
);
    import lpht_pkg::*;

    localparam int PW     = $clog2(TABLE_SIZE);
    localparam int ENT_W  = SSTATE_W + KEY_BITS;
    localparam int DIV_W  = 2 * MID_W;
    localparam int STP_W  = 1;
    localparam int RCP_SH = 2 * MID_W;
    localparam int RCP    = ((1 << RCP_SH) + TABLE_SIZE - 1) / TABLE_SIZE;
    localparam int PRD_W  = MID_W + RCP_SH;

    fsm_t                  state_reg, state_next;
    logic [REQ_W-1:0]      req_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [MID_W-1:0]      rem_reg, rem_next;
    logic [MID_W-1:0]      quo_reg, quo_next;
    logic [STP_W-1:0]      step_reg, step_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [PW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    logic [ENT_W-1:0]      slot_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] slot_vld_reg;
    logic [ENT_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;
    logic                  wr_en;
    logic [ENT_W-1:0]      wr_data;

    logic [SQ_W-1:0]       sq;
    logic [PRD_W-1:0]      rcp_prod;
    logic [DIV_W-1:0]      quo_mul;
    logic [MID_W-1:0]      rem_step;
    logic [SSTATE_W-1:0]   cur_state;
    logic [KEY_BITS-1:0]   cur_key;
    logic                  key_hit;
    logic                  last_probe;
    logic [PW-1:0]         ptr_inc;
    logic                  probe_end;

    // squarer and reciprocal-multiply reducer; the quotient is exact for any 8-bit hash
    assign sq       = SQ_W'(key_reg) * SQ_W'(key_reg);
    assign rcp_prod = PRD_W'(rem_reg) * PRD_W'(RCP);
    assign quo_mul  = DIV_W'(quo_reg) * DIV_W'(TABLE_SIZE);
    assign rem_step = rem_reg - quo_mul[MID_W-1:0];

    // slot without a valid bit reads as never used
    assign cur_state  = rd_vld_reg ? rd_data_reg[ENT_W-1 -: SSTATE_W] : SS_EMPTY;
    assign cur_key    = rd_data_reg[KEY_BITS-1:0];
    assign key_hit    = (cur_state == SS_USED) && (cur_key == key_reg);
    assign last_probe = (cnt_reg == PW'(TABLE_SIZE - 1));
    assign ptr_inc    = (ptr_reg == PW'(TABLE_SIZE - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        probe_end = 1'b1;
        case (req_reg) inside
            REQ_INSERT:             probe_end = (cur_state != SS_USED) || last_probe;
            REQ_SEARCH, REQ_DELETE: probe_end = key_hit || (cur_state == SS_EMPTY) || last_probe;
            default:                probe_end = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_HASH;
            ST_HASH:  state_next = ST_MOD;
            ST_MOD:   if (step_reg == '0) state_next = ST_PROBE;
            ST_PROBE: if (probe_end) state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        wr_en       = 1'b0;
        wr_data     = rd_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_HASH:
            begin
                rem_next  = sq[MID_LSB +: MID_W];
                step_next = '1;
            end
            ST_MOD:
            begin
                step_next = step_reg - 1'b1;
                cnt_next  = '0;
                if (step_reg != '0)
                    quo_next = rcp_prod[RCP_SH +: MID_W];
                else
                    ptr_next = PW'(rem_step);
            end
            ST_PROBE:
            begin
                ptr_next = ptr_inc;
                cnt_next = cnt_reg + 1'b1;
                if (probe_end)
                begin
                    done_next   = 1'b1;
                    status_next = RES_MISSING;
                    slot_next   = '0;
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            if (cur_state != SS_USED)
                            begin
                                wr_en       = 1'b1;
                                wr_data     = {SS_USED, key_reg};
                                status_next = RES_INSERTED;
                                slot_next   = SLOT_W'(ptr_reg);
                            end
                            else
                                status_next = RES_FULL;
                        end
                        REQ_SEARCH:
                        begin
                            if (key_hit)
                            begin
                                status_next = RES_FOUND;
                                slot_next   = SLOT_W'(ptr_reg);
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (key_hit)
                            begin
                                wr_en       = 1'b1;
                                wr_data     = {SS_GONE, cur_key};
                                status_next = RES_DELETED;
                                slot_next   = SLOT_W'(ptr_reg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            slot_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (wr_en)
                slot_vld_reg[ptr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg <= req_type;
            key_reg <= key[KEY_BITS-1:0];
        end
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        rd_vld_reg <= slot_vld_reg[ptr_next];
    end

    // slot memory: one write port at the probe pointer, registered read one probe ahead
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[ptr_reg] <= wr_data;
        rd_data_reg <= slot_mem[ptr_next];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted transaction did not start the sequencer");

    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == RES_FULL || status == RES_MISSING) |-> slot == '0)
        else $error("failed request reported a nonzero slot");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= RES_DELETED)
        else $error("status code out of range");

endmodule

// ===== dv/tb.sv =====
// Testbench for the linear-probe hash table: directed and random requests, scoreboard checking.
`timescale 1ns / 1ps

module tb;
    import lpht_pkg::*;

    localparam int TABLE_SIZE  = 11;
    localparam int POOL_SIZE   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    // request code with no operation behind it
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } lookup_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [REQ_W-1:0]    req_type = REQ_INSERT;
    logic [KEY_W-1:0]    key = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    // shadow copy of the table contents
    logic [SSTATE_W-1:0] tbl_state [TABLE_SIZE];
    logic [KEY_W-1:0]    tbl_key [TABLE_SIZE];

    lookup_result_t      pending_results[$];
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  send_gap_pct = 12;
    int                  status_seen [5];
    int                  result_count = 0;

    linear_probe_hash_table_unit #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_BITS(KEY_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req_type(req_type),
        .key(key),
        .busy(busy),
        .done(done),
        .status(status),
        .slot(slot)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int home_index(input logic [KEY_W-1:0] k);
        logic [SQ_W-1:0] sq;
        sq = SQ_W'(k) * SQ_W'(k);
        return int'(sq[MID_LSB +: MID_W]) % TABLE_SIZE;
    endfunction

    // applies one request to the shadow table and returns the expected result
    function automatic lookup_result_t apply_request(input logic [REQ_W-1:0] rq,
                                                     input logic [KEY_W-1:0] k);
        lookup_result_t r;
        int p;
        r.status = RES_MISSING;
        r.slot = '0;
        p = home_index(k);
        if (rq == REQ_INSERT)
        begin
            r.status = RES_FULL;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                if (tbl_state[p] != SS_USED)
                begin
                    tbl_state[p] = SS_USED;
                    tbl_key[p] = k;
                    r.status = RES_INSERTED;
                    r.slot = SLOT_W'(p);
                    break;
                end
                p = (p + 1 == TABLE_SIZE) ? 0 : p + 1;
            end
        end
        else if (rq == REQ_SEARCH || rq == REQ_DELETE)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                if (tbl_state[p] == SS_USED && tbl_key[p] == k)
                begin
                    if (rq == REQ_DELETE)
                    begin
                        tbl_state[p] = SS_GONE;
                        r.status = RES_DELETED;
                    end
                    else
                    begin
                        r.status = RES_FOUND;
                    end
                    r.slot = SLOT_W'(p);
                    break;
                end
                if (tbl_state[p] == SS_EMPTY)
                    break;
                p = (p + 1 == TABLE_SIZE) ? 0 : p + 1;
            end
        end
        return r;
    endfunction

    // drives one request and waits until the block takes it
    task automatic send_request(input logic [REQ_W-1:0] rq, input logic [KEY_W-1:0] k);
        start <= 1'b1;
        req_type <= rq;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_request(rq, k));
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d slot=%0d",
                                          status, slot));
            end
            else
            begin
                exp_r = pending_results.pop_front();
                result_count++;
                if (exp_r.status <= RES_DELETED)
                    status_seen[exp_r.status]++;
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status exp %0d got %0d",
                                              exp_r.status, status));
                if (slot !== exp_r.slot)
                    report_mismatch($sformatf("slot exp %0d got %0d", exp_r.slot, slot));
            end
        end
    end

    // extremes of the key, duplicates, tombstones, unused request code
    task automatic test_basic_ops();
        send_request(REQ_SEARCH, 16'h0000);
        send_request(REQ_INSERT, 16'h0000);
        send_request(REQ_INSERT, 16'h0000);
        send_request(REQ_INSERT, 16'hFFFF);
        send_request(REQ_SEARCH, 16'hFFFF);
        send_request(REQ_DELETE, 16'h0000);
        send_request(REQ_SEARCH, 16'h0000);
        send_request(REQ_DELETE, 16'hFFFF);
        send_request(REQ_SEARCH, 16'hFFFF);
        send_request(REQ_RESERVED, 16'hFFFF);
        send_request(REQ_DELETE, 16'h1234);
    endtask

    // fill every slot, then search for and delete an absent key across all slots
    task automatic test_table_full();
        logic [KEY_W-1:0] absent;
        logic             hit;
        for (int i = 0; i < TABLE_SIZE - 1; i++)
            send_request(REQ_INSERT, key_pool[i]);
        send_request(REQ_INSERT, key_pool[TABLE_SIZE - 1]);
        do
        begin
            absent = KEY_W'($urandom_range(0, 65535));
            hit = 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++)
                if (tbl_state[i] == SS_USED && tbl_key[i] == absent)
                    hit = 1'b1;
        end
        while (hit);
        send_request(REQ_SEARCH, absent);
        send_request(REQ_DELETE, absent);
    endtask

    // inserts use a small key pool so searches and deletes hit; misses use any key
    task automatic test_random_traffic(input int n_items, input int gap_pct);
        int pick;
        logic [KEY_W-1:0] k;
        send_gap_pct = gap_pct;
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 33 && $urandom_range(0, 99) < 20)
                k = KEY_W'($urandom_range(0, 65535));
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 33)
                send_request(REQ_INSERT, k);
            else if (pick < 64)
                send_request(REQ_SEARCH, k);
            else if (pick < 95)
                send_request(REQ_DELETE, k);
            else
                send_request(REQ_RESERVED, k);
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            tbl_state[i] = SS_EMPTY;
            tbl_key[i] = '0;
        end
        for (int i = 0; i < 5; i++)
            status_seen[i] = 0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 65535));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_table_full();
        test_random_traffic(340, 12);
        test_random_traffic(340, 64);
        test_random_traffic(340, 0);
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d transactions in %0d cycles", result_count, cycle_count);
        $display("  inserted %0d, full %0d, found %0d, not found %0d, deleted %0d",
                 status_seen[RES_INSERTED], status_seen[RES_FULL], status_seen[RES_FOUND],
                 status_seen[RES_MISSING], status_seen[RES_DELETED]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lpht_pkg.sv
design/linear_probe_hash_table_unit.sv
dv/tb.sv
